// ===== sv/vad_pkg.sv =====
// ----------------------------------------------------------------------------
// vad_pkg: shared types and constants for the vertex attribute dedup block
// Table sizing, field widths, controller state and command/status bundles.
// ----------------------------------------------------------------------------
package vad_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int REF_W       = 20;
	localparam int KEY_W       = 2 * REF_W;
	localparam int OUT_IDX_W   = 10;
	localparam int OUT_CNT_W   = 11;
	localparam int S_DATA_W    = ((KEY_W + 7) / 8) * 8;
	localparam int M_DATA_W    = ((OUT_IDX_W + OUT_CNT_W + 7) / 8) * 8;
	localparam int M_USER_W    = 2;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} vad_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic issue;
		logic commit;
	} vad_cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_done;
		logic pending;
		logic out_free;
	} vad_status_t;

	function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[OUT_IDX_W-1:0];
	endfunction

	function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[OUT_CNT_W-1:0];
	endfunction

endpackage

// ===== sv/vad_ctrl.sv =====
// ----------------------------------------------------------------------------
// vad_ctrl: controller for the vertex attribute dedup block
// Accepts one transaction, steps the table scan and commits the result.
// ----------------------------------------------------------------------------
module vad_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output vad_pkg::vad_cmd_t    cmd,
	input  vad_pkg::vad_status_t st
);
	import vad_pkg::*;

	vad_state_t state_q;
	vad_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan  = 1'b1;
				cmd.issue = !st.scan_done;
				if (st.hit || (st.scan_done && !st.pending)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/vad_datapath.sv =====
// ----------------------------------------------------------------------------
// vad_datapath: pair table, scan counter and result register
// Holds the distinct pairs in a single-port-read memory and compares one
// stored pair per cycle against the current key.
// ----------------------------------------------------------------------------
module vad_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vad_pkg::vad_cmd_t               cmd,
	output vad_pkg::vad_status_t            st,
	input  logic [vad_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [vad_pkg::M_DATA_W-1:0]    m_tdata,
	output logic [vad_pkg::M_USER_W-1:0]    m_tuser
);
	import vad_pkg::*;

	logic [KEY_W-1:0]     mem_q [TABLE_DEPTH];
	logic [KEY_W-1:0]     key_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     scan_q;
	logic                 rd_valid_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic [KEY_W-1:0]     rd_data_q;
	logic                 found_q;
	logic [CNT_W-1:0]     found_idx_q;
	logic                 m_valid_q;
	logic [OUT_IDX_W-1:0] out_index_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 is_new_q;
	logic                 ovf_q;
	logic                 hit;
	logic                 full;
	logic                 append;

	assign hit    = rd_valid_q && (rd_data_q == key_q);
	assign full   = (fill_q == DEPTH_CNT);
	assign append = cmd.commit && !found_q && !full;

	assign st.hit       = hit;
	assign st.scan_done = (scan_q >= fill_q);
	assign st.pending   = rd_valid_q;
	assign st.out_free  = !m_valid_q || m_tready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			scan_q     <= '0;
			rd_valid_q <= 1'b0;
			found_q    <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			rd_valid_q <= cmd.issue;
			if (cmd.load) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				if (s_tuser) begin
					fill_q <= '0;
				end
			end else if (cmd.issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (cmd.scan && hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (append) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= s_tdata[KEY_W-1:0];
		end
		if (cmd.issue) begin
			rd_idx_q <= scan_q;
		end
		if (cmd.scan && hit && !found_q) begin
			found_idx_q <= rd_idx_q;
		end
		if (cmd.commit) begin
			if (found_q) begin
				out_index_q <= to_out_idx(found_idx_q);
				count_q     <= to_out_cnt(fill_q);
				is_new_q    <= 1'b0;
				ovf_q       <= 1'b0;
			end else if (full) begin
				out_index_q <= '0;
				count_q     <= to_out_cnt(fill_q);
				is_new_q    <= 1'b0;
				ovf_q       <= 1'b1;
			end else begin
				out_index_q <= to_out_idx(fill_q);
				count_q     <= to_out_cnt(fill_q + CNT_W'(1));
				is_new_q    <= 1'b1;
				ovf_q       <= 1'b0;
			end
		end
	end

	// pair table
	always_ff @(posedge clk) begin
		if (append) begin
			mem_q[fill_q[ADDR_W-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_data_q <= mem_q[scan_q[ADDR_W-1:0]];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W - OUT_IDX_W - OUT_CNT_W){1'b0}}, count_q, out_index_q};
	assign m_tuser  = {ovf_q, is_new_q};

`ifndef SYNTHESIS
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_valid_q || m_tready))
		else $error("result committed while output register still held");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_CNT)
		else $error("fill count beyond table depth");

	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (scan_q < fill_q))
		else $error("table read beyond filled entries");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && hit) |-> (rd_idx_q < fill_q))
		else $error("match reported outside filled entries");

	a_append_on_room: assert property (@(posedge clk) disable iff (!arst_n)
		append |=> (fill_q == $past(fill_q) + CNT_W'(1)) && m_valid_q)
		else $error("append did not advance fill count");
`endif

endmodule

// ===== sv/vertex_attribute_dedup.sv =====
// ----------------------------------------------------------------------------
// vertex_attribute_dedup: face corner deduplication
// Maps (position, texcoord) index pairs onto a table of distinct vertices.
// ----------------------------------------------------------------------------
// One corner is handled at a time. A corner is accepted, then the stored
// pairs are read back one per cycle from the table memory, oldest first,
// and compared with it; the single read port sets the rate. A match at
// table position k ends the scan and returns k as out_index. A pair that
// is not found among the stored pairs is appended, or flagged as overflow
// when the table is full. The next corner is accepted in the cycle after
// the result is loaded into the output register, even while that result
// still waits to be taken. tuser set on a corner empties the table first.
// A full table answers a new pair with the overflow flag.
// ----------------------------------------------------------------------------
module vertex_attribute_dedup (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [19:0] position_ref, [39:20] texcoord_ref
	input  logic [vad_pkg::S_DATA_W-1:0] s_tdata,
	// [0] new_mesh
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [9:0] out_index, [20:10] distinct_count, [23:21] zero
	output logic [vad_pkg::M_DATA_W-1:0] m_tdata,
	// [0] is_new, [1] overflow
	output logic [vad_pkg::M_USER_W-1:0] m_tuser
);
	import vad_pkg::*;

	vad_cmd_t    cmd;
	vad_status_t st;

	vad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	vad_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
